FILE: rtl/lzss_pkg.sv
package lzss_pkg;

	// History window size in bytes.
	localparam int HISTORY_DEPTH = 4096;

	// Fixed field widths of the compressed format.
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int DIST_W   = 12;
	localparam int LEN_W    = 5;
	localparam int BITS_W   = 4;

	// Length nibble bias and control bits per flag byte.
	localparam logic [LEN_W-1:0]  LEN_BIAS      = LEN_W'(3);
	localparam logic [BITS_W-1:0] BITS_PER_FLAG = BITS_W'(8);

	// Parser phase codes.
	typedef enum logic [1:0] {
		PH_FLAG = 2'd0,
		PH_ITEM = 2'd1,
		PH_REF2 = 2'd2,
		PH_RSVD = 2'd3
	} phase_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DATA     = 2'd0,
		ST_ZERO_REF = 2'd1,
		ST_RAN_OUT  = 2'd2,
		ST_BAD_DIST = 2'd3
	} status_t;

endpackage

FILE: rtl/lzss_in_if.sv
interface lzss_in_if;
	logic                             valid;
	logic                             ready;
	logic [lzss_pkg::BYTE_W-1:0]      in_byte;
	logic                             blob_start;
	logic                             blob_end;

	modport source (output valid, output in_byte, output blob_start, output blob_end,
		input ready);
	modport sink (input valid, input in_byte, input blob_start, input blob_end,
		output ready);
endinterface

FILE: rtl/lzss_out_if.sv
interface lzss_out_if;
	logic                             valid;
	logic                             ready;
	logic [lzss_pkg::BYTE_W-1:0]      out_byte;
	logic [lzss_pkg::STATUS_W-1:0]    status;
	logic                             run_last;

	modport source (output valid, output out_byte, output status, output run_last,
		input ready);
	modport sink (input valid, input out_byte, input status, input run_last,
		output ready);
endinterface

FILE: rtl/lzss_ram.sv
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/lzss_flag_byte_decompressor_core.sv
// LZSS flag-byte decompressor (12-bit back distance, 4-bit length).
// The din channel takes one compressed byte per transaction, with blob_start
// marking the first byte of a blob and blob_end the last one. The dout channel
// gives decompressed bytes (status data) and one status result when a blob
// ends by a zero reference, by running out of input, or on a bad distance.
// run_last marks the final result caused by one input byte.
// Flow: a byte is taken into an item register and worked on in the next
// cycle. Each copied byte of a reference (3 to 18 bytes) is read through
// the single registered read port of the history RAM in a read state, then
// written back at the write pointer in a copy state, which lets overlapping
// copies work. A trailing ran-out status is given from its own end state.
// din.ready is high only while the sequencer waits for a new byte.
// Results pass through one output register; while the receiver stalls, the
// sequencer holds its current step and resumes when the register frees up.
// Reset clears the parser state, counters and output valid. The history RAM
// is not cleared; a blob only reads bytes it has written itself.
module lzss_flag_byte_decompressor_core #(
	parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	lzss_in_if.sink    din,
	lzss_out_if.source dout
);

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int PCW = AW + 1;
	localparam logic [PCW-1:0] PC_MAX = PCW'(HISTORY_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_RD   = 5'b00100,
		S_CP   = 5'b01000,
		S_END  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Parser state.
	logic [lzss_pkg::BYTE_W-1:0] ctrl_q, ctrl_d;
	logic [lzss_pkg::BITS_W-1:0] bits_q, bits_d;
	lzss_pkg::phase_t            phase_q, phase_d;
	logic [lzss_pkg::BYTE_W-1:0] dlow_q, dlow_d;
	logic [AW-1:0]               wp_q, wp_d;
	logic [PCW-1:0]              pc_q, pc_d;
	logic                        fin_q, fin_d;

	// Current item and copy state.
	logic [lzss_pkg::BYTE_W-1:0] b_q;
	logic                        end_q;
	logic [lzss_pkg::DIST_W-1:0] dist_q, dist_d;
	logic [lzss_pkg::LEN_W-1:0]  cnt_q, cnt_d;

	// Output register.
	logic                          ov_q;
	logic [lzss_pkg::BYTE_W-1:0]   ob_q;
	logic [lzss_pkg::STATUS_W-1:0] ost_q;
	logic                          olast_q;

	// Emit request from the sequencer.
	logic                          emit;
	logic [lzss_pkg::BYTE_W-1:0]   e_byte;
	lzss_pkg::status_t             e_status;
	logic                          e_last;

	logic                        can_emit;
	logic                        accept;
	logic                        ram_we;
	logic [lzss_pkg::BYTE_W-1:0] ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [lzss_pkg::BYTE_W-1:0] ram_rdata;

	logic [lzss_pkg::DIST_W-1:0] ref_dist;
	logic [lzss_pkg::BITS_W-1:0] bits_dec;

	assign can_emit  = !ov_q || dout.ready;
	assign din.ready = (state_q == S_IDLE);
	assign accept    = din.valid && din.ready;

	// Read address unit: the copy source sits dist bytes behind the write pointer.
	assign ram_raddr = wp_q - AW'(dist_q);

	assign ref_dist = {b_q[7:4], dlow_q};
	assign bits_dec = (bits_q != '0) ? bits_q - lzss_pkg::BITS_W'(1) : bits_q;

	lzss_ram #(
		.WIDTH (lzss_pkg::BYTE_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		ctrl_d    = ctrl_q;
		bits_d    = bits_q;
		phase_d   = phase_q;
		dlow_d    = dlow_q;
		wp_d      = wp_q;
		pc_d      = pc_q;
		fin_d     = fin_q;
		dist_d    = dist_q;
		cnt_d     = cnt_q;
		emit      = 1'b0;
		e_byte    = '0;
		e_status  = lzss_pkg::ST_DATA;
		e_last    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = b_q;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
					if (din.blob_start) begin
						pc_d    = '0;
						fin_d   = 1'b0;
						phase_d = lzss_pkg::PH_FLAG;
						bits_d  = '0;
					end
				end
			end
			S_EXEC: begin
				if (fin_q) begin
					state_d = S_IDLE;
				end else if (phase_q == lzss_pkg::PH_ITEM) begin
					if (ctrl_q[0]) begin
						// Literal byte.
						if (can_emit) begin
							emit      = 1'b1;
							e_byte    = b_q;
							e_last    = !end_q;
							ram_we    = 1'b1;
							ram_wdata = b_q;
							wp_d      = wp_q + AW'(1);
							pc_d      = (pc_q != PC_MAX) ? pc_q + PCW'(1) : pc_q;
							ctrl_d    = ctrl_q >> 1;
							bits_d    = bits_dec;
							phase_d   = (bits_dec == '0) ? lzss_pkg::PH_FLAG
								: lzss_pkg::PH_ITEM;
							state_d   = end_q ? S_END : S_IDLE;
						end
					end else begin
						// First byte of a reference.
						dlow_d  = b_q;
						phase_d = lzss_pkg::PH_REF2;
						state_d = end_q ? S_END : S_IDLE;
					end
				end else if (phase_q == lzss_pkg::PH_REF2) begin
					if (dlow_q == '0 && b_q == '0) begin
						if (can_emit) begin
							emit     = 1'b1;
							e_status = lzss_pkg::ST_ZERO_REF;
							e_last   = 1'b1;
							fin_d    = 1'b1;
							state_d  = S_IDLE;
						end
					end else if (ref_dist == '0 || PCW'(ref_dist) > pc_q) begin
						if (can_emit) begin
							emit     = 1'b1;
							e_status = lzss_pkg::ST_BAD_DIST;
							e_last   = 1'b1;
							fin_d    = 1'b1;
							state_d  = S_IDLE;
						end
					end else begin
						// Valid reference: start the copy loop.
						dist_d  = ref_dist;
						cnt_d   = lzss_pkg::LEN_W'(b_q[3:0]) + lzss_pkg::LEN_BIAS;
						ctrl_d  = ctrl_q >> 1;
						bits_d  = bits_dec;
						phase_d = (bits_dec == '0) ? lzss_pkg::PH_FLAG
							: lzss_pkg::PH_ITEM;
						state_d = S_RD;
					end
				end else begin
					// Flag byte; the unused phase code is treated the same way.
					ctrl_d  = b_q;
					bits_d  = lzss_pkg::BITS_PER_FLAG;
					phase_d = lzss_pkg::PH_ITEM;
					state_d = end_q ? S_END : S_IDLE;
				end
			end
			S_RD: begin
				state_d = S_CP;
			end
			S_CP: begin
				// Copy one history byte and append it to the history.
				if (can_emit) begin
					emit      = 1'b1;
					e_byte    = ram_rdata;
					e_last    = (cnt_q == lzss_pkg::LEN_W'(1)) && !end_q;
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					wp_d      = wp_q + AW'(1);
					pc_d      = (pc_q != PC_MAX) ? pc_q + PCW'(1) : pc_q;
					cnt_d     = cnt_q - lzss_pkg::LEN_W'(1);
					if (cnt_q == lzss_pkg::LEN_W'(1)) begin
						state_d = end_q ? S_END : S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_END: begin
				if (can_emit) begin
					emit     = 1'b1;
					e_status = lzss_pkg::ST_RAN_OUT;
					e_last   = 1'b1;
					fin_d    = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control and parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctrl_q  <= '0;
			bits_q  <= '0;
			phase_q <= lzss_pkg::PH_FLAG;
			dlow_q  <= '0;
			wp_q    <= '0;
			pc_q    <= '0;
			fin_q   <= 1'b0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ctrl_q  <= ctrl_d;
			bits_q  <= bits_d;
			phase_q <= phase_d;
			dlow_q  <= dlow_d;
			wp_q    <= wp_d;
			pc_q    <= pc_d;
			fin_q   <= fin_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			b_q   <= din.in_byte;
			end_q <= din.blob_end;
		end
		dist_q <= dist_d;
		if (emit) begin
			ob_q    <= e_byte;
			ost_q   <= e_status;
			olast_q <= e_last;
		end
	end

	assign dout.valid    = ov_q;
	assign dout.out_byte = ob_q;
	assign dout.status   = ost_q;
	assign dout.run_last = olast_q;

endmodule
